### sv/rort_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the range offset remap table.
// Has no dependencies; every other file of the block imports it.
package rort_pkg;

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_CLEAR  = 2'd1;
    localparam logic [1:0] CMD_MAP    = 2'd2;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_DUP  = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] value;
        logic [31:0] span;
        logic [31:0] target_base;
    } in_item_t;

    typedef struct packed {
        logic [32:0] mapped;
        logic        hit;
        logic [1:0]  status;
    } out_item_t;

    typedef enum logic [1:0] {
        OP_INSERT,
        OP_CLEAR,
        OP_MAP,
        OP_NOP
    } op_t;

    typedef struct packed {
        op_t         op;
        logic [31:0] value;
        logic [31:0] span;
        logic [31:0] target_base;
    } job_t;

    typedef struct packed {
        logic [31:0] start;
        logic [31:0] length;
        logic [31:0] target;
    } entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_SCAN,
        BK_DONE,
        BK_RESULT
    } back_state_t;

endpackage

### sv/range_offset_remap_table.sv
`timescale 1ns / 1ps
// Top level of the range offset remap table: decode stage, job queue and
// table engine. Depends on rort_pkg, rort_front, rort_queue and rort_back.
//
// The block keeps up to MAX_RANGES ranges (start, length, destination) in a
// single-port-write, registered-read memory and answers insert, clear and map
// transactions with one result each. Insert and map jobs walk the stored
// entries one per cycle through the memory read port; clear and unused
// commands skip the scan. A two-entry queue lets new transactions be
// accepted while the engine scans, and the registered result may wait for
// m_ready while the next job is already being processed. No clearing pass
// is needed after reset.
module range_offset_remap_table #(
    parameter int MAX_RANGES = 64
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  rort_pkg::in_item_t  s_item,
    output logic                m_valid,
    input  logic                m_ready,
    output rort_pkg::out_item_t m_item
);
    import rort_pkg::*;

    logic      q_push;
    logic      q_pop;
    job_t      q_push_data;
    job_t      q_head;
    q_status_t q_stat;

    rort_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_item      (s_item),
        .q_stat      (q_stat),
        .q_push      (q_push),
        .q_push_data (q_push_data)
    );

    rort_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_push_data),
        .pop       (q_pop),
        .head      (q_head),
        .stat      (q_stat)
    );

    rort_back #(
        .MAX_RANGES (MAX_RANGES)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_head  (q_head),
        .q_stat  (q_stat),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

endmodule

### sv/rort_front.sv
`timescale 1ns / 1ps
// Input stage: accepts transactions and decodes the command into a job.
// Depends on rort_pkg; feeds rort_queue.
module rort_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  rort_pkg::in_item_t  s_item,
    input  rort_pkg::q_status_t q_stat,
    output logic                q_push,
    output rort_pkg::job_t      q_push_data
);
    import rort_pkg::*;

    logic valid_reg;
    logic valid_next;
    job_t job_reg;
    job_t job_next;
    op_t  op_dec;
    logic accept;

    always_comb begin
        unique case (s_item.cmd)
            CMD_INSERT: op_dec = OP_INSERT;
            CMD_CLEAR:  op_dec = OP_CLEAR;
            CMD_MAP:    op_dec = OP_MAP;
            default:    op_dec = OP_NOP;
        endcase
    end

    assign q_push      = valid_reg && !q_stat.full;
    assign s_ready     = !valid_reg || q_push;
    assign accept      = s_valid && s_ready;
    assign q_push_data = job_reg;

    always_comb begin
        valid_next = valid_reg;
        job_next   = job_reg;
        if (accept) begin
            valid_next           = 1'b1;
            job_next.op          = op_dec;
            job_next.value       = s_item.value;
            job_next.span        = s_item.span;
            job_next.target_base = s_item.target_base;
        end else if (q_push) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        job_reg <= job_next;
    end

endmodule

### sv/rort_queue.sv
`timescale 1ns / 1ps
// Short job queue between the decode stage and the table engine.
// Depends on rort_pkg.
module rort_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  rort_pkg::job_t      push_data,
    input  logic                pop,
    output rort_pkg::job_t      head,
    output rort_pkg::q_status_t stat
);
    import rort_pkg::*;

    job_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg;
    logic [QCNT_W-1:0] cnt_next;
    logic              do_push;
    logic              do_pop;

    assign stat.full  = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign stat.empty = (cnt_reg == '0);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign head       = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + QCNT_W'(1);
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### sv/rort_back.sv
`timescale 1ns / 1ps
// Table engine: holds the range memory, scans it for each insert or map job and
// registers the result transaction. Depends on rort_pkg; fed by rort_queue.
module rort_back #(
    parameter int MAX_RANGES = 64
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  rort_pkg::job_t      q_head,
    input  rort_pkg::q_status_t q_stat,
    output logic                q_pop,
    output logic                m_valid,
    input  logic                m_ready,
    output rort_pkg::out_item_t m_item
);
    import rort_pkg::*;

    localparam int CNT_W = $clog2(MAX_RANGES + 1);
    localparam int IDX_W = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;

    back_state_t state_reg;
    back_state_t state_next;

    entry_t      entry_mem_reg [MAX_RANGES];
    entry_t      rd_data_reg;
    logic [IDX_W-1:0] rd_addr;
    logic [IDX_W-1:0] wr_addr;
    entry_t      wr_data;

    job_t        job_reg;
    job_t        job_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic [CNT_W-1:0] scan_idx_reg;
    logic [CNT_W-1:0] scan_idx_next;
    logic        data_valid_reg;
    logic        data_valid_next;
    logic        found_reg;
    logic        found_next;
    logic        dup_reg;
    logic        dup_next;
    entry_t      best_reg;
    entry_t      best_next;
    logic [31:0] off_reg;
    logic [31:0] off_next;
    logic [1:0]  status_reg;
    logic [1:0]  status_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    out_item_t   out_item_reg;
    out_item_t   out_item_next;

    logic        issue;
    logic        scan_end;
    logic        out_load;
    logic        mem_we;
    logic        table_full;

    assign table_full = (cnt_reg >= CNT_W'(MAX_RANGES));
    assign rd_addr    = scan_idx_reg[IDX_W-1:0];
    assign wr_addr    = cnt_reg[IDX_W-1:0];
    assign wr_data    = '{start: job_reg.value, length: job_reg.span,
                          target: job_reg.target_base};
    assign scan_end   = (scan_idx_reg >= cnt_reg) && !data_valid_reg;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE: begin
                if (!q_stat.empty) begin
                    if (q_head.op == OP_INSERT || q_head.op == OP_MAP) begin
                        state_next = BK_SCAN;
                    end else begin
                        state_next = BK_RESULT;
                    end
                end
            end
            BK_SCAN: begin
                if (scan_end) begin
                    state_next = BK_DONE;
                end
            end
            BK_DONE: begin
                state_next = BK_RESULT;
            end
            BK_RESULT: begin
                if (!out_valid_reg || m_ready) begin
                    state_next = BK_IDLE;
                end
            end
            default: begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_comb begin
        q_pop    = 1'b0;
        issue    = 1'b0;
        out_load = 1'b0;
        mem_we   = 1'b0;
        unique case (state_reg)
            BK_IDLE: begin
                q_pop = !q_stat.empty;
            end
            BK_SCAN: begin
                issue = (scan_idx_reg < cnt_reg);
            end
            BK_DONE: begin
                mem_we = (job_reg.op == OP_INSERT) && !dup_reg && !table_full;
            end
            BK_RESULT: begin
                out_load = !out_valid_reg || m_ready;
            end
            default: begin
                q_pop = 1'b0;
            end
        endcase
    end

    always_comb begin
        job_next        = job_reg;
        cnt_next        = cnt_reg;
        scan_idx_next   = scan_idx_reg;
        data_valid_next = issue;
        found_next      = found_reg;
        dup_next        = dup_reg;
        best_next       = best_reg;
        off_next        = off_reg;
        status_next     = status_reg;
        out_valid_next  = out_valid_reg;
        out_item_next   = out_item_reg;

        if (q_pop) begin
            job_next      = q_head;
            scan_idx_next = '0;
            found_next    = 1'b0;
            dup_next      = 1'b0;
        end

        if (issue) begin
            scan_idx_next = scan_idx_reg + CNT_W'(1);
        end

        if (data_valid_reg) begin
            if (job_reg.op == OP_MAP) begin
                if (rd_data_reg.start <= job_reg.value &&
                    (!found_reg || rd_data_reg.start > best_reg.start)) begin
                    found_next = 1'b1;
                    best_next  = rd_data_reg;
                end
            end else if (rd_data_reg.start == job_reg.value) begin
                dup_next = 1'b1;
            end
        end

        if (state_reg == BK_DONE) begin
            off_next = job_reg.value - best_reg.start;
            if (dup_reg) begin
                status_next = ST_DUP;
            end else if (table_full) begin
                status_next = ST_FULL;
            end else begin
                status_next = ST_OK;
            end
        end

        if (mem_we) begin
            cnt_next = cnt_reg + CNT_W'(1);
        end

        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end

        if (out_load) begin
            out_valid_next = 1'b1;
            out_item_next  = '0;
            case (job_reg.op)
                OP_INSERT: begin
                    out_item_next.status = status_reg;
                end
                OP_CLEAR: begin
                    cnt_next = '0;
                end
                OP_MAP: begin
                    if (found_reg && off_reg < best_reg.length) begin
                        out_item_next.mapped = {1'b0, best_reg.target} + {1'b0, off_reg};
                        out_item_next.hit    = 1'b1;
                    end else begin
                        out_item_next.mapped = {1'b0, job_reg.value};
                    end
                end
                default: begin
                    out_item_next = '0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= BK_IDLE;
            cnt_reg        <= '0;
            data_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            data_valid_reg <= data_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        job_reg      <= job_next;
        scan_idx_reg <= scan_idx_next;
        found_reg    <= found_next;
        dup_reg      <= dup_next;
        best_reg     <= best_next;
        off_reg      <= off_next;
        status_reg   <= status_next;
        out_item_reg <= out_item_next;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            entry_mem_reg[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data_reg <= entry_mem_reg[rd_addr];
    end

    assign m_valid = out_valid_reg;
    assign m_item  = out_item_reg;

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == BK_SCAN) |-> (scan_idx_reg <= cnt_reg))
        else $error("Scan index ran past the entry count.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == BK_DONE && job_reg.op == OP_INSERT && !dup_reg && !table_full)
        |=> (cnt_reg == $past(cnt_reg) + CNT_W'(1)))
        else $error("Accepted insert did not grow the table.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == BK_IDLE) |-> !data_valid_reg)
        else $error("Memory read still in flight while idle.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_item_reg.hit) |-> (out_item_reg.status == ST_OK))
        else $error("Mapped result carries a nonzero status.");

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// Testbench for range_offset_remap_table: a directed script followed by random episodes
// of clears, inserts, maps and unused commands; results are checked against the script
// or a behavioral predictor. Depends on rort_pkg and the range_offset_remap_table RTL.
module tb;
    import rort_pkg::*;

    localparam int          TABLE_DEPTH  = 64;
    localparam int          RANDOM_ITEMS = 950;
    localparam int          LIMIT_CYCLES = 1000000;
    localparam int          DRAIN_CYCLES = TABLE_DEPTH + 16;
    localparam int          REPORT_CAP   = 10;
    localparam logic [1:0]  CMD_UNUSED   = 2'd3;
    localparam logic [31:0] FILL_STRIDE  = 32'h0001_0000;

    typedef struct {
        in_item_t    item;
        int unsigned reps;
        bit          typed;
        out_item_t   want;
    } script_row_t;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_item = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_item;

    logic [31:0] range_lo    [TABLE_DEPTH];
    logic [31:0] range_len   [TABLE_DEPTH];
    logic [31:0] range_dst   [TABLE_DEPTH];
    int unsigned ranges_held = 0;

    out_item_t   due_results [$];
    script_row_t script [$];
    int          send_idle_pct = 16;
    int          recv_idle_pct = 87;
    int unsigned fail_count = 0;
    int unsigned cycle_count = 0;
    int unsigned n_insert = 0;
    int unsigned n_dup = 0;
    int unsigned n_full = 0;
    int unsigned n_clear = 0;
    int unsigned n_map = 0;
    int unsigned n_hit = 0;

    range_offset_remap_table #(
        .MAX_RANGES(TABLE_DEPTH)
    ) dut (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_item (s_item),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_item (m_item)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        wait (cycle_count >= LIMIT_CYCLES);
        $display("tb NOT OK");
        $finish;
    end

    function automatic in_item_t make_item(input logic [1:0] cmd, input logic [31:0] value,
                                           input logic [31:0] span,
                                           input logic [31:0] target_base);
        in_item_t it;
        it.cmd         = cmd;
        it.value       = value;
        it.span        = span;
        it.target_base = target_base;
        return it;
    endfunction

    function automatic out_item_t translate_item(input in_item_t it);
        out_item_t   r;
        logic [31:0] off;
        int          best;
        bit          dup;
        r = '0;
        case (it.cmd)
            CMD_INSERT: begin
                n_insert++;
                dup = 1'b0;
                for (int i = 0; i < ranges_held; i++) begin
                    if (range_lo[i] == it.value) begin
                        dup = 1'b1;
                    end
                end
                if (dup) begin
                    r.status = ST_DUP;
                    n_dup++;
                end else if (ranges_held >= TABLE_DEPTH) begin
                    r.status = ST_FULL;
                    n_full++;
                end else begin
                    range_lo[ranges_held]  = it.value;
                    range_len[ranges_held] = it.span;
                    range_dst[ranges_held] = it.target_base;
                    ranges_held++;
                end
            end
            CMD_CLEAR: begin
                n_clear++;
                ranges_held = 0;
            end
            CMD_MAP: begin
                n_map++;
                best = -1;
                for (int i = 0; i < ranges_held; i++) begin
                    if (range_lo[i] <= it.value &&
                        (best < 0 || range_lo[i] > range_lo[best])) begin
                        best = i;
                    end
                end
                r.mapped = {1'b0, it.value};
                if (best >= 0) begin
                    off = it.value - range_lo[best];
                    if (off < range_len[best]) begin
                        r.mapped = {1'b0, range_dst[best]} + {1'b0, off};
                        r.hit    = 1'b1;
                        n_hit++;
                    end
                end
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    task automatic flag_failure(input string msg);
        fail_count++;
        if (fail_count <= REPORT_CAP) begin
            $display("%s", msg);
        end
    endtask

    task automatic add_row(input logic [1:0] cmd, input logic [31:0] value,
                           input logic [31:0] span, input logic [31:0] dst,
                           input int unsigned reps, input bit typed,
                           input logic [32:0] mapped, input logic hit,
                           input logic [1:0] status);
        script_row_t row;
        row.item        = make_item(cmd, value, span, dst);
        row.reps        = reps;
        row.typed       = typed;
        row.want.mapped = mapped;
        row.want.hit    = hit;
        row.want.status = status;
        script.push_back(row);
    endtask

    // Returns at the edge that accepts the transaction, with s_valid still high.
    task automatic issue(input in_item_t it, input bit typed, input out_item_t want);
        int unsigned gap;
        out_item_t   predicted;
        gap = 0;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            gap++;
        end
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= it;
        do @(posedge aclk); while (!s_ready);
        predicted = translate_item(it);
        due_results.push_back(typed ? want : predicted);
    endtask

    task automatic set_idling(input int unsigned done);
        if (done < RANDOM_ITEMS / 3) begin
            send_idle_pct = 16;
            recv_idle_pct = 87;
        end else if (done < 2 * RANDOM_ITEMS / 3) begin
            send_idle_pct = 87;
            recv_idle_pct = 16;
        end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
    endtask

    always @(posedge aclk) begin : result_check
        out_item_t want;
        m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        if (aresetn && m_valid && m_ready) begin
            if (due_results.size() == 0) begin
                flag_failure($sformatf("unexpected result: mapped=%h hit=%b status=%0d",
                                       m_item.mapped, m_item.hit, m_item.status));
            end else begin
                want = due_results.pop_front();
                if (m_item.mapped !== want.mapped || m_item.hit !== want.hit ||
                    m_item.status !== want.status) begin
                    flag_failure($sformatf(
                        {"mismatch: expected mapped=%h hit=%b status=%0d,",
                         " got mapped=%h hit=%b status=%0d"},
                        want.mapped, want.hit, want.status,
                        m_item.mapped, m_item.hit, m_item.status));
                end
            end
        end
    end

    initial begin : stimulus
        in_item_t    it;
        int unsigned n_ins;
        int unsigned n_probe;
        int unsigned k;
        int unsigned sel;
        int unsigned random_sent;
        bit          clustered;
        logic [31:0] base;
        logic [31:0] len;

        add_row(CMD_MAP, 32'h0, 32'h0, 32'h0, 1, 1'b1, 33'h0, 1'b0, ST_OK);
        add_row(CMD_MAP, '1, '1, '1, 1, 1'b1, 33'h0_FFFF_FFFF, 1'b0, ST_OK);
        add_row(CMD_INSERT, 32'h0, '1, '1, 1, 1'b1, 33'h0, 1'b0, ST_OK);
        add_row(CMD_MAP, 32'hFFFF_FFFE, 32'h0, 32'h0, 1, 1'b1, 33'h1_FFFF_FFFD, 1'b1, ST_OK);
        add_row(CMD_MAP, '1, 32'h0, 32'h0, 1, 1'b1, 33'h0_FFFF_FFFF, 1'b0, ST_OK);
        add_row(CMD_INSERT, 32'h0, 32'h5, 32'h5, 1, 1'b1, 33'h0, 1'b0, ST_DUP);
        add_row(CMD_INSERT, '1, 32'h0, 32'h0, 1, 1'b1, 33'h0, 1'b0, ST_OK);
        add_row(CMD_MAP, '1, 32'h0, 32'h0, 1, 1'b1, 33'h0_FFFF_FFFF, 1'b0, ST_OK);
        add_row(CMD_UNUSED, '1, '1, '1, 1, 1'b1, 33'h0, 1'b0, ST_OK);
        add_row(CMD_CLEAR, '1, '1, '1, 1, 1'b1, 33'h0, 1'b0, ST_OK);
        add_row(CMD_MAP, 32'd5, 32'h0, 32'h0, 1, 1'b1, 33'd5, 1'b0, ST_OK);
        add_row(CMD_INSERT, 32'd100, 32'd10, 32'd1000, 1, 1'b1, 33'h0, 1'b0, ST_OK);
        add_row(CMD_INSERT, 32'd50, 32'd20, 32'd7, 1, 1'b1, 33'h0, 1'b0, ST_OK);
        add_row(CMD_MAP, 32'd49, 32'h0, 32'h0, 1, 1'b1, 33'd49, 1'b0, ST_OK);
        add_row(CMD_MAP, 32'd55, '1, '1, 1, 1'b0, 33'h0, 1'b0, ST_OK);
        add_row(CMD_MAP, 32'd70, 32'h0, 32'h0, 1, 1'b0, 33'h0, 1'b0, ST_OK);
        add_row(CMD_MAP, 32'd109, 32'h0, 32'h0, 1, 1'b0, 33'h0, 1'b0, ST_OK);
        add_row(CMD_MAP, 32'd110, 32'h0, 32'h0, 1, 1'b0, 33'h0, 1'b0, ST_OK);
        add_row(CMD_CLEAR, 32'h0, 32'h0, 32'h0, 1, 1'b1, 33'h0, 1'b0, ST_OK);
        add_row(CMD_INSERT, 32'h1000_0000, 32'h8000, 32'h8000_0000, TABLE_DEPTH, 1'b1,
                33'h0, 1'b0, ST_OK);
        add_row(CMD_INSERT, 32'h1, 32'h1, 32'h1, 1, 1'b1, 33'h0, 1'b0, ST_FULL);
        add_row(CMD_INSERT, 32'h1000_0000, 32'h1, 32'h1, 1, 1'b1, 33'h0, 1'b0, ST_DUP);
        add_row(CMD_MAP, 32'h1003_7FFF, 32'h0, 32'h0, 1, 1'b0, 33'h0, 1'b0, ST_OK);
        add_row(CMD_MAP, 32'h1003_8000, 32'h0, 32'h0, 1, 1'b0, 33'h0, 1'b0, ST_OK);
        add_row(CMD_MAP, 32'h0FFF_FFFF, 32'h0, 32'h0, 1, 1'b0, 33'h0, 1'b0, ST_OK);
        add_row(CMD_MAP, 32'h103F_0000, 32'h0, 32'h0, 1, 1'b0, 33'h0, 1'b0, ST_OK);
        add_row(CMD_MAP, '1, 32'h0, 32'h0, 1, 1'b0, 33'h0, 1'b0, ST_OK);
        add_row(CMD_CLEAR, 32'h0, 32'h0, 32'h0, 1, 1'b1, 33'h0, 1'b0, ST_OK);

        set_idling(0);
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (script[r]) begin
            for (int j = 0; j < script[r].reps; j++) begin
                it = script[r].item;
                it.value       = it.value + j * FILL_STRIDE;
                it.target_base = it.target_base + j * FILL_STRIDE;
                issue(it, script[r].typed, script[r].want);
            end
        end

        // Each episode optionally clears, loads a batch of ranges and then probes
        // mostly around their boundaries; clustered episodes pack ranges so they may overlap.
        random_sent = 0;
        while (random_sent < RANDOM_ITEMS) begin
            set_idling(random_sent);
            clustered = 1'($urandom_range(0, 1));
            if ($urandom_range(0, 3) == 0) begin
                issue(make_item(CMD_CLEAR, $urandom, $urandom, $urandom), 1'b0, '0);
                random_sent++;
            end
            n_ins = ($urandom_range(0, 7) == 0) ? 70 : $urandom_range(0, 24);
            for (int i = 0; i < n_ins; i++) begin
                sel = $urandom_range(0, 9);
                if (sel == 0 && ranges_held != 0) begin
                    base = range_lo[$urandom_range(0, ranges_held - 1)];
                end else if (clustered) begin
                    base = $urandom_range(0, 32'h3FFF);
                end else begin
                    base = $urandom;
                end
                case ($urandom_range(0, 9))
                    0: len = 32'h0;
                    1: len = 32'hFFFF_FFFF;
                    2: len = $urandom;
                    default: len = clustered ? $urandom_range(1, 32'h200)
                                             : $urandom_range(1, 32'hF_FFFF);
                endcase
                issue(make_item(CMD_INSERT, base, len, $urandom), 1'b0, '0);
                random_sent++;
                if ($urandom_range(0, 19) == 0) begin
                    issue(make_item(CMD_UNUSED, $urandom, $urandom, $urandom), 1'b0, '0);
                end
            end
            n_probe = $urandom_range(4, 30);
            for (int i = 0; i < n_probe; i++) begin
                sel = $urandom_range(0, 9);
                if (sel < 6 && ranges_held != 0) begin
                    k    = $urandom_range(0, ranges_held - 1);
                    base = range_lo[k];
                    len  = range_len[k];
                    case ($urandom_range(0, 4))
                        0: begin
                        end
                        1: base = base + len - 1;
                        2: base = base + len;
                        3: base = base - 1;
                        default: begin
                            if (len != 0) begin
                                base = base + $urandom_range(0, len - 1);
                            end
                        end
                    endcase
                end else if (sel < 8) begin
                    base = clustered ? $urandom_range(0, 32'h4FFF) : $urandom;
                end else begin
                    base = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
                end
                issue(make_item(CMD_MAP, base, $urandom, $urandom), 1'b0, '0);
                random_sent++;
            end
        end

        s_valid <= 1'b0;
        while (due_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Covered %0d inserts (%0d duplicate, %0d on a full table), %0d clears,",
                 n_insert, n_dup, n_full, n_clear);
        $display("%0d maps with %0d hits over %0d cycles of staggered stalls; %0d failures.",
                 n_map, n_hit, cycle_count, fail_count);
        if (fail_count == 0 && due_results.size() == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule

### sim.f
sv/rort_pkg.sv
sv/rort_front.sv
sv/rort_queue.sv
sv/rort_back.sv
sv/range_offset_remap_table.sv
tb/tb.sv
